// ----- design/plti_pkg.sv -----
// Shared types and codes for the piecewise linear table interpolator.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package plti_pkg;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_START,
		DP_SHIFT,
		DP_PAIR,
		DP_FIRST,
		DP_SECOND,
		DP_SETUP,
		DP_MUL,
		DP_DIVCHK,
		DP_DIV,
		DP_ROUND,
		DP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   anc_hi;
		logic   wr;
	} dp_cmd_t;

	typedef struct packed {
		logic gt;
		logic zero;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- design/plti_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module plti_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- design/plti_datapath.sv -----
// Datapath: point table, search compare, serial multiply and divide, output registers.
// Depends on plti_pkg and plti_ram.
`timescale 1ns / 1ps
`default_nettype none

module plti_datapath #(
	parameter int MAX_POINTS  = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire plti_pkg::dp_cmd_t             cmd,
	output plti_pkg::dp_stat_t                 stat,
	input  wire logic [$clog2(MAX_POINTS)-1:0] rd_addr,
	input  wire logic [$clog2(MAX_POINTS)-1:0] point_index,
	input  wire logic [VALUE_WIDTH-1:0]        x_value,
	input  wire logic [VALUE_WIDTH-1:0]        f_value,
	output logic      [VALUE_WIDTH-1:0]        result,
	output logic                               saturated,
	output logic                               extrapolated
);

	localparam int VW = VALUE_WIDTH;
	localparam int AW = $clog2(MAX_POINTS);

	logic [2*VW-1:0] rd_data;
	logic [VW-1:0]   rd_x, rd_f;
	logic            ram_we;

	logic [VW-1:0] x_q, prev_x_q, prev_f_q, lo_x_q, lo_f_q, hi_x_q, hi_f_q;
	logic          anc_hi_q, extra_q;
	logic [VW-1:0] dx_q, df_q, f_q, acc_q, low_q;
	logic          neg_q, zero_q, ovf_q;
	logic [VW:0]   qr_q;

	logic [VW-1:0] anc_x, anc_f, dxm, dfm, dqm;
	logic          ndx, ndf, ndq;
	logic [VW:0]   mul_sum, div_t, div_diff;
	logic          div_ge, round_up;
	logic [VW+1:0] fin_sum, fin_max, fin_min;
	logic          fin_sat;

	assign ram_we = cmd.wr && ({1'b0, point_index} < (AW+1)'(MAX_POINTS));

	plti_ram #(
		.WIDTH(2*VW),
		.DEPTH(MAX_POINTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(point_index),
		.wdata({x_value, f_value}),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign rd_x = rd_data[2*VW-1:VW];
	assign rd_f = rd_data[VW-1:0];

	assign stat.gt   = $signed(rd_x) > $signed(x_q);
	assign stat.zero = zero_q;

	always_comb begin
		anc_x = anc_hi_q ? hi_x_q : lo_x_q;
		anc_f = anc_hi_q ? hi_f_q : lo_f_q;
		ndx   = $signed(lo_x_q) > $signed(hi_x_q);
		ndf   = $signed(lo_f_q) > $signed(hi_f_q);
		ndq   = $signed(anc_x) > $signed(x_q);
		dxm   = ndx ? lo_x_q - hi_x_q : hi_x_q - lo_x_q;
		dfm   = ndf ? lo_f_q - hi_f_q : hi_f_q - lo_f_q;
		dqm   = ndq ? anc_x - x_q : x_q - anc_x;
	end

	assign mul_sum  = {1'b0, acc_q} + {1'b0, (low_q[0] ? df_q : {VW{1'b0}})};
	assign div_t    = {acc_q, low_q[VW-1]};
	assign div_ge   = div_t >= {1'b0, dx_q};
	assign div_diff = div_t - {1'b0, dx_q};
	assign round_up = {acc_q, 1'b0} >= {1'b0, dx_q};

	assign fin_max = {3'b000, {(VW-1){1'b1}}};
	assign fin_min = {3'b111, {(VW-1){1'b0}}};

	always_comb begin
		if (neg_q) begin
			fin_sum = {{2{f_q[VW-1]}}, f_q} - {1'b0, qr_q};
			fin_sat = ovf_q || ($signed(fin_sum) < $signed(fin_min));
		end else begin
			fin_sum = {{2{f_q[VW-1]}}, f_q} + {1'b0, qr_q};
			fin_sat = ovf_q || ($signed(fin_sum) > $signed(fin_max));
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			plti_pkg::DP_START: begin
				x_q <= x_value;
			end
			plti_pkg::DP_SHIFT: begin
				prev_x_q <= rd_x;
				prev_f_q <= rd_f;
			end
			plti_pkg::DP_PAIR: begin
				lo_x_q   <= prev_x_q;
				lo_f_q   <= prev_f_q;
				hi_x_q   <= rd_x;
				hi_f_q   <= rd_f;
				anc_hi_q <= cmd.anc_hi;
				extra_q  <= cmd.anc_hi && ($signed(x_q) > $signed(rd_x));
			end
			plti_pkg::DP_FIRST: begin
				lo_x_q   <= rd_x;
				lo_f_q   <= rd_f;
				anc_hi_q <= 1'b0;
				extra_q  <= 1'b1;
			end
			plti_pkg::DP_SECOND: begin
				hi_x_q <= rd_x;
				hi_f_q <= rd_f;
			end
			plti_pkg::DP_SETUP: begin
				dx_q   <= dxm;
				df_q   <= dfm;
				acc_q  <= '0;
				low_q  <= dqm;
				f_q    <= anc_f;
				neg_q  <= ndx ^ ndf ^ ndq;
				zero_q <= (hi_x_q == lo_x_q) || (hi_f_q == lo_f_q) || (x_q == anc_x);
			end
			plti_pkg::DP_MUL: begin
				acc_q <= mul_sum[VW:1];
				low_q <= {mul_sum[0], low_q[VW-1:1]};
			end
			plti_pkg::DP_DIVCHK: begin
				ovf_q <= acc_q >= dx_q;
			end
			plti_pkg::DP_DIV: begin
				acc_q <= div_ge ? div_diff[VW-1:0] : div_t[VW-1:0];
				low_q <= {low_q[VW-2:0], div_ge};
			end
			plti_pkg::DP_ROUND: begin
				qr_q <= {1'b0, low_q} + {{VW{1'b0}}, round_up};
			end
			plti_pkg::DP_FINISH: begin
				extrapolated <= extra_q;
				if (zero_q) begin
					result    <= f_q;
					saturated <= 1'b0;
				end else if (fin_sat) begin
					result    <= neg_q ? fin_min[VW-1:0] : fin_max[VW-1:0];
					saturated <= 1'b1;
				end else begin
					result    <= fin_sum[VW-1:0];
					saturated <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- design/plti_ctrl.sv -----
// Controller: transfer handshakes, point count register, search and arithmetic sequencing.
// Depends on plti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plti_ctrl #(
	parameter int MAX_POINTS  = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            op,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	input  wire logic                            point_count_we,
	input  wire logic [$clog2(MAX_POINTS+1)-1:0] point_count_data,
	output plti_pkg::dp_cmd_t                    cmd,
	input  wire plti_pkg::dp_stat_t              stat,
	output logic      [$clog2(MAX_POINTS)-1:0]   rd_addr
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int SW = $clog2(VALUE_WIDTH);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FETCH  = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_SECOND = 4'd3;
	localparam logic [3:0] S_SETUP  = 4'd4;
	localparam logic [3:0] S_CHECK  = 4'd5;
	localparam logic [3:0] S_MUL    = 4'd6;
	localparam logic [3:0] S_DIVCHK = 4'd7;
	localparam logic [3:0] S_DIV    = 4'd8;
	localparam logic [3:0] S_ROUND  = 4'd9;
	localparam logic [3:0] S_FINISH = 4'd10;

	logic [3:0]    state_q, state_d;
	logic [CW-1:0] count_q, idx_q, idx_d;
	logic [SW-1:0] step_q, step_d;
	logic          out_valid_q, finish;

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign rd_addr   = idx_q[AW-1:0];
	assign finish    = (state_q == S_FINISH) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		step_d     = step_q;
		cmd.op     = plti_pkg::DP_NOP;
		cmd.anc_hi = 1'b0;
		cmd.wr     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				idx_d = '0;
				if (in_valid) begin
					if (op == plti_pkg::OP_QUERY) begin
						cmd.op  = plti_pkg::DP_START;
						state_d = S_FETCH;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			S_FETCH: begin
				idx_d   = CW'(1);
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (stat.gt) begin
					if (idx_q == CW'(1)) begin
						cmd.op  = plti_pkg::DP_FIRST;
						state_d = S_SECOND;
					end else begin
						cmd.op  = plti_pkg::DP_PAIR;
						state_d = S_SETUP;
					end
				end else if (idx_q == count_q) begin
					cmd.op     = plti_pkg::DP_PAIR;
					cmd.anc_hi = 1'b1;
					state_d    = S_SETUP;
				end else begin
					cmd.op = plti_pkg::DP_SHIFT;
					idx_d  = idx_q + CW'(1);
				end
			end
			S_SECOND: begin
				cmd.op  = plti_pkg::DP_SECOND;
				state_d = S_SETUP;
			end
			S_SETUP: begin
				cmd.op  = plti_pkg::DP_SETUP;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				step_d  = SW'(VALUE_WIDTH - 1);
				state_d = stat.zero ? S_FINISH : S_MUL;
			end
			S_MUL: begin
				cmd.op = plti_pkg::DP_MUL;
				step_d = step_q - SW'(1);
				if (step_q == '0) begin
					state_d = S_DIVCHK;
				end
			end
			S_DIVCHK: begin
				cmd.op  = plti_pkg::DP_DIVCHK;
				step_d  = SW'(VALUE_WIDTH - 1);
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = plti_pkg::DP_DIV;
				step_d = step_q - SW'(1);
				if (step_q == '0) begin
					state_d = S_ROUND;
				end
			end
			S_ROUND: begin
				cmd.op  = plti_pkg::DP_ROUND;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (finish) begin
					cmd.op  = plti_pkg::DP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			step_q      <= '0;
			count_q     <= CW'(2);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			step_q  <= step_d;
			if (point_count_we) begin
				if (point_count_data < CW'(2)) begin
					count_q <= CW'(2);
				end else if (point_count_data > CW'(MAX_POINTS)) begin
					count_q <= CW'(MAX_POINTS);
				end else begin
					count_q <= point_count_data;
				end
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/piecewise_linear_table_interp_top.sv -----
// Piecewise linear table interpolator: holds (x, f) points in Q16.16 and answers queries.
// Input items load one table point (op 0) or query a value (op 1); one result per query.
// Configuration: point_count_we with point_count_data sets how many points a query uses
// (clamped to 2 .. MAX_POINTS, 2 after reset); write it only while the block is idle.
// Input transfer: in_valid high and in_stall low at a rising edge. in_stall is low only in
// the idle state, so loads transfer one per cycle and are written to the table at once.
// A query walks the table one point per cycle from slot 0 (one table read port), then runs
// a bit-serial multiply and a bit-serial restoring divide of VALUE_WIDTH steps each.
// The scan stops at the first point with x above the query, or after point_count points;
// a segment with equal x or equal f, or a query on an anchor point, skips the multiply and
// divide and goes straight to the final state.
// The result sits in an output register: while out_stall holds it, further loads and one
// more query proceed, and that query waits in its final state until the register is free.
// Reset clears the controller and output valid; table contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_table_interp_top #(
	parameter int MAX_POINTS  = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            op,
	input  wire logic [$clog2(MAX_POINTS)-1:0]   point_index,
	input  wire logic [VALUE_WIDTH-1:0]          x_value,
	input  wire logic [VALUE_WIDTH-1:0]          f_value,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [VALUE_WIDTH-1:0]          result,
	output logic                                 saturated,
	output logic                                 extrapolated,
	input  wire logic                            point_count_we,
	input  wire logic [$clog2(MAX_POINTS+1)-1:0] point_count_data
);

	plti_pkg::dp_cmd_t               cmd;
	plti_pkg::dp_stat_t              stat;
	logic [$clog2(MAX_POINTS)-1:0]   rd_addr;

	plti_ctrl #(
		.MAX_POINTS (MAX_POINTS),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.op              (op),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.point_count_we  (point_count_we),
		.point_count_data(point_count_data),
		.cmd             (cmd),
		.stat            (stat),
		.rd_addr         (rd_addr)
	);

	plti_datapath #(
		.MAX_POINTS (MAX_POINTS),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_datapath (
		.clk         (clk),
		.cmd         (cmd),
		.stat        (stat),
		.rd_addr     (rd_addr),
		.point_index (point_index),
		.x_value     (x_value),
		.f_value     (f_value),
		.result      (result),
		.saturated   (saturated),
		.extrapolated(extrapolated)
	);

endmodule

`default_nettype wire

// ----- bench/piecewise_linear_table_interp_top_tb.sv -----
// Self-checking bench for the piecewise linear table interpolator: loads table points,
// issues queries and checks result, saturated and extrapolated against a built-in predictor.
// Depends on plti_pkg and piecewise_linear_table_interp_top.
`timescale 1ns / 1ps

module piecewise_linear_table_interp_top_tb;

	localparam int NUM_SLOTS       = 64;
	localparam int DRAIN_CYCLES    = 200;
	localparam int HOLD_OFF_CYCLES = 1500;
	localparam int CYCLE_LIMIT     = 2000000;
	localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
	localparam logic signed [127:0] Q_MIN = -128'sd2147483648;

	typedef enum int {SHAPE_DENSE, SHAPE_WIDE, SHAPE_REPEATS, SHAPE_SCRAMBLED} table_shape_t;

	typedef struct packed {
		logic [31:0] value;
		logic        sat;
		logic        extra;
	} query_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [5:0]  point_index;
	logic [31:0] x_value;
	logic [31:0] f_value;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] result;
	logic        saturated;
	logic        extrapolated;
	logic        point_count_we;
	logic [6:0]  point_count_data;

	logic signed [31:0] abscissa_mem [NUM_SLOTS];
	logic signed [31:0] ordinate_mem [NUM_SLOTS];
	logic [6:0]         point_count_setting = 7'd2;
	query_result_t      pending_results [$];
	query_result_t      want;
	int                 error_count = 0;
	int                 cycle_count = 0;
	bit                 idle_on = 1'b1;
	bit                 hold_request = 1'b0;

	piecewise_linear_table_interp_top DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.op               (op),
		.point_index      (point_index),
		.x_value          (x_value),
		.f_value          (f_value),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result           (result),
		.saturated        (saturated),
		.extrapolated     (extrapolated),
		.point_count_we   (point_count_we),
		.point_count_data (point_count_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("piecewise_linear_table_interp_top_tb: errors");
			$finish;
		end
	end

	function automatic int active_points();
		if (point_count_setting < 2)
			return 2;
		if (point_count_setting > NUM_SLOTS)
			return NUM_SLOTS;
		return point_count_setting;
	endfunction

	function automatic query_result_t predict_query(logic [31:0] xq);
		query_result_t      r;
		int                 n;
		int                 idx;
		int                 lo_i;
		int                 hi_i;
		int                 anc;
		bit                 found;
		bit                 neg;
		longint             xs;
		longint             dx;
		longint             df;
		longint             dq;
		logic [127:0]       dxm;
		logic [127:0]       dfm;
		logic [127:0]       dqm;
		logic [127:0]       prod;
		logic [127:0]       quot;
		logic [127:0]       remd;
		logic signed [127:0] val;
		n = active_points();
		xs = longint'($signed(xq));
		found = 1'b0;
		idx = n;
		for (int i = 0; i < n; i++)
			if (!found && longint'(abscissa_mem[i]) > xs) begin
				found = 1'b1;
				idx = i;
			end
		if (!found) begin
			lo_i = n - 2;
			hi_i = n - 1;
			anc = hi_i;
			r.extra = xs > longint'(abscissa_mem[hi_i]);
		end else if (idx == 0) begin
			lo_i = 0;
			hi_i = 1;
			anc = 0;
			r.extra = 1'b1;
		end else begin
			lo_i = idx - 1;
			hi_i = idx;
			anc = lo_i;
			r.extra = 1'b0;
		end
		dx = longint'(abscissa_mem[hi_i]) - longint'(abscissa_mem[lo_i]);
		df = longint'(ordinate_mem[hi_i]) - longint'(ordinate_mem[lo_i]);
		dq = xs - longint'(abscissa_mem[anc]);
		dxm = (dx < 0) ? -dx : dx;
		dfm = (df < 0) ? -df : df;
		dqm = (dq < 0) ? -dq : dq;
		neg = (dx < 0) ^ (df < 0) ^ (dq < 0);
		r.sat = 1'b0;
		if (dxm == 0 || dfm == 0 || dqm == 0) begin
			r.value = ordinate_mem[anc];
		end else begin
			prod = dfm * dqm;
			quot = prod / dxm;
			remd = prod % dxm;
			// round half away from zero on the magnitude
			if (remd >= dxm - remd)
				quot = quot + 1;
			val = longint'(ordinate_mem[anc]);
			if (neg)
				val = val - $signed(quot);
			else
				val = val + $signed(quot);
			if (val > Q_MAX) begin
				val = Q_MAX;
				r.sat = 1'b1;
			end else if (val < Q_MIN) begin
				val = Q_MIN;
				r.sat = 1'b1;
			end
			r.value = val[31:0];
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(30, 60);
	endfunction

	function automatic logic [31:0] pick_query_x();
		int     n;
		int     i;
		int     r;
		longint lo;
		longint span;
		n = active_points();
		i = $urandom_range(0, n - 2);
		r = $urandom_range(0, 9);
		lo = longint'(abscissa_mem[i]);
		span = longint'(abscissa_mem[i + 1]) - lo;
		if (r < 6)
			return (span > 0) ? 32'(lo + longint'($urandom) % span) : 32'(lo);
		if (r < 8)
			return abscissa_mem[$urandom_range(0, n - 1)] + $urandom_range(0, 2) - 1;
		return $urandom;
	endfunction

	task automatic send_item(input logic kind, input logic [5:0] slot,
			input logic [31:0] xv, input logic [31:0] fv);
		int gap;
		bit took;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		point_index <= slot;
		x_value <= xv;
		f_value <= fv;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
		if (kind == plti_pkg::OP_LOAD) begin
			abscissa_mem[slot] = xv;
			ordinate_mem[slot] = fv;
		end else begin
			pending_results = {pending_results, predict_query(xv)};
		end
	endtask

	task automatic wait_until_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_point_count(input logic [6:0] v);
		wait_until_drained();
		point_count_we <= 1'b1;
		point_count_data <= v;
		@(posedge clk);
		point_count_we <= 1'b0;
		point_count_setting = v;
	endtask

	task automatic fill_table(input table_shape_t shape);
		longint      xcur;
		longint      step;
		logic [31:0] fcur;
		xcur = longint'($urandom_range(0, 32'h3FFF_FFFF)) - 64'sd2147483648;
		fcur = $urandom;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			case (shape)
				SHAPE_DENSE: step = $urandom_range(1, 1000);
				SHAPE_WIDE: step = $urandom_range(1, 1 << 25);
				SHAPE_REPEATS: step = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 1 << 20);
				default: step = 0;
			endcase
			if (shape == SHAPE_SCRAMBLED)
				xcur = longint'($signed($urandom));
			else if (i > 0)
				xcur = xcur + step;
			fcur = ($urandom_range(0, 3) == 0) ? $urandom : fcur + $urandom_range(0, 1 << 21) - (1 << 20);
			send_item(plti_pkg::OP_LOAD, 6'(i), xcur[31:0], fcur);
		end
	endtask

	task automatic run_mixed_traffic(input int count);
		int          slot;
		longint      lo;
		longint      span;
		logic [31:0] xv;
		repeat (count) begin
			if ($urandom_range(0, 4) != 0) begin
				send_item(plti_pkg::OP_QUERY, 6'($urandom_range(0, 63)), pick_query_x(),
					$urandom);
			end else begin
				slot = $urandom_range(0, NUM_SLOTS - 1);
				xv = abscissa_mem[slot];
				if ($urandom_range(0, 9) == 0) begin
					xv = $urandom;
				end else if (slot > 0 && slot < NUM_SLOTS - 1) begin
					// keep the table ordered: land strictly between the neighbors
					lo = longint'(abscissa_mem[slot - 1]);
					span = longint'(abscissa_mem[slot + 1]) - lo;
					if (span > 1)
						xv = 32'(lo + 1 + longint'($urandom) % (span - 1));
				end
				send_item(plti_pkg::OP_LOAD, 6'(slot), xv, $urandom);
			end
		end
	endtask

	task automatic test_two_point_segment();
		send_item(plti_pkg::OP_LOAD, 6'd0, -32'sd65536, 32'd0);
		send_item(plti_pkg::OP_LOAD, 6'd1, 32'd65536, 32'd131072);
		send_item(plti_pkg::OP_QUERY, 6'd0, 32'd0, 32'd0);
		send_item(plti_pkg::OP_QUERY, 6'd0, -32'sd65536, 32'd0);
		send_item(plti_pkg::OP_QUERY, 6'd0, 32'd65536, 32'hFFFF_FFFF);
		send_item(plti_pkg::OP_QUERY, 6'd0, 32'h8000_0000, 32'd0);
		send_item(plti_pkg::OP_QUERY, 6'd0, 32'h7FFF_FFFF, 32'd0);
	endtask

	task automatic test_saturation_limits();
		send_item(plti_pkg::OP_LOAD, 6'd0, -32'sd1, 32'h8000_0000);
		send_item(plti_pkg::OP_LOAD, 6'd1, 32'd1, 32'h7FFF_FFFF);
		send_item(plti_pkg::OP_QUERY, 6'd0, 32'h7FFF_FFFF, 32'd0);
		send_item(plti_pkg::OP_QUERY, 6'd0, 32'h8000_0000, 32'd0);
	endtask

	task automatic test_degenerate_segments();
		// equal abscissae, then a decreasing table
		send_item(plti_pkg::OP_LOAD, 6'd1, -32'sd1, 32'd5);
		send_item(plti_pkg::OP_QUERY, 6'd0, 32'd100, 32'd0);
		send_item(plti_pkg::OP_LOAD, 6'd1, -32'sd100, 32'd1000);
		send_item(plti_pkg::OP_QUERY, 6'd0, 32'd0, 32'd0);
	endtask

	task automatic test_rounding_ties();
		send_item(plti_pkg::OP_LOAD, 6'd0, 32'd0, 32'd0);
		send_item(plti_pkg::OP_LOAD, 6'd1, 32'd2, 32'd1);
		send_item(plti_pkg::OP_QUERY, 6'd0, 32'd1, 32'd0);
		send_item(plti_pkg::OP_LOAD, 6'd1, 32'd2, -32'sd1);
		send_item(plti_pkg::OP_QUERY, 6'd0, 32'd1, 32'd0);
		send_item(plti_pkg::OP_QUERY, 6'd0, 32'd3, 32'd0);
	endtask

	task automatic test_field_extremes();
		send_item(plti_pkg::OP_LOAD, 6'd63, 32'h7FFF_FFFF, 32'h8000_0000);
		send_item(plti_pkg::OP_LOAD, 6'd62, 32'h8000_0000, 32'h7FFF_FFFF);
	endtask

	task automatic test_point_count_sweep();
		logic [6:0] settings [9];
		settings = '{7'd127, 7'd64, 7'd0, 7'd1, 7'd2, 7'd3, 7'd65,
			7'($urandom_range(2, 64)), 7'($urandom_range(0, 127))};
		for (int k = 0; k < 9; k++) begin
			write_point_count(settings[k]);
			idle_on = (k % 3 != 1);
			fill_table(table_shape_t'(k % 4));
			run_mixed_traffic(110);
		end
		idle_on = 1'b1;
	endtask

	task automatic test_backpressure();
		write_point_count(7'd64);
		idle_on = 1'b0;
		hold_request = 1'b1;
		repeat (12)
			send_item(plti_pkg::OP_QUERY, 6'($urandom_range(0, 63)), pick_query_x(), $urandom);
		idle_on = 1'b1;
	endtask

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat (pick_gap()) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected transfer: result %h saturated %b extrapolated %b",
					result, saturated, extrapolated);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (result !== want.value) begin
					$error("result: expected %h, got %h", want.value, result);
					error_count++;
				end
				if (saturated !== want.sat) begin
					$error("saturated: expected %b, got %b", want.sat, saturated);
					error_count++;
				end
				if (extrapolated !== want.extra) begin
					$error("extrapolated: expected %b, got %b", want.extra, extrapolated);
					error_count++;
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= plti_pkg::OP_LOAD;
		point_index <= '0;
		x_value <= '0;
		f_value <= '0;
		point_count_we <= 1'b0;
		point_count_data <= 7'd2;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_two_point_segment();
		test_saturation_limits();
		test_degenerate_segments();
		test_rounding_ties();
		test_field_extremes();
		test_point_count_sweep();
		test_backpressure();
		wait_until_drained();
		if (error_count == 0)
			$display("piecewise_linear_table_interp_top_tb: clean");
		else
			$display("piecewise_linear_table_interp_top_tb: errors");
		$finish;
	end

endmodule
